// File: rtl/bta_pkg.sv
// Package for the buddy allocator: sizes, codes, state type.
package bta_pkg;
	localparam int TOTAL_UNITS = 1024;
	localparam int MAX_IDS = 16;
	localparam int NODE_SLOTS = 2 * TOTAL_UNITS - 1;
	localparam int LEVELS = $clog2(TOTAL_UNITS) + 1;
	localparam int NW = 11;
	localparam int IW = 4;
	localparam int SZW = 11;
	localparam int LW = $clog2(LEVELS + 1);

	typedef logic [NW-1:0] node_t;
	typedef logic [1:0] nst_t;
	localparam nst_t ST_FREE = 2'd0;
	localparam nst_t ST_SPLIT = 2'd1;
	localparam nst_t ST_OCC = 2'd2;

	localparam logic [2:0] S_ALLOC = 3'd0;
	localparam logic [2:0] S_FREED = 3'd1;
	localparam logic [2:0] S_NOSPACE = 3'd2;
	localparam logic [2:0] S_NOID = 3'd3;
	localparam logic [2:0] S_BADSIZE = 3'd4;
	localparam logic [2:0] S_UNUSED = 3'd5;

	typedef enum logic [3:0] {
		ST_IDLE, ST_LEVEL, ST_SCAN, ST_SCAN_W, ST_ANC, ST_ANC_W, ST_MARK,
		ST_FREE_RD, ST_FREE_W, ST_DONE
	} fsm_t;

	// memory port request from the sequencer
	typedef struct packed {
		logic re;
		logic we;
		node_t addr;
		nst_t wdata;
	} mreq_t;
endpackage

// File: rtl/bta_node_mem.sv
// Node state memory: one port, registered read, cleared to free by a pass after reset.
module bta_node_mem (
	input logic clk,
	input logic arst_n,
	input bta_pkg::mreq_t req,
	output logic clearing,
	output bta_pkg::nst_t rdata
);
	import bta_pkg::*;
	nst_t mem [NODE_SLOTS];
	nst_t rd_q;
	node_t clr_q;
	logic clr_act_q;
	logic we;
	node_t waddr;
	nst_t wdata;

	// clearing pass owns the write port after reset until every node slot is cleared
	assign we = clr_act_q | req.we;
	assign waddr = clr_act_q ? clr_q : req.addr;
	assign wdata = clr_act_q ? ST_FREE : req.wdata;

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (req.re) rd_q <= mem[req.addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			clr_act_q <= 1'b1;
		end else if (clr_act_q) begin
			if (clr_q == node_t'(NODE_SLOTS - 1)) clr_act_q <= 1'b0;
			clr_q <= clr_q + 1'b1;
		end
	end

	assign clearing = clr_act_q;
	assign rdata = rd_q;
endmodule

// File: rtl/buddy_tree_allocator_top.sv
// Buddy allocator top: sequencer over the node state memory and the id table.
// Reset: async, no ids; a clearing pass then frees all nodes, busy high.
// Allocate: one level tried per cycle (up to 11), then each scanned node is read and its
// ancestors checked, then one write per level from the found node up to the root.
// Free: frees the node, reads its sibling and merges upward while the sibling is free.
// One word per command, busy high from start to the result strobe.
module buddy_tree_allocator_top (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic func,
	input logic [10:0] req_size,
	input logic [3:0] free_id,
	output logic done,
	output logic [2:0] status,
	output logic [3:0] alloc_id,
	output logic [10:0] tree_node
);
	import bta_pkg::*;

	fsm_t st_q, st_d;
	node_t cur_q, cur_d, last_q, last_d, anc_q, anc_d, node_q, node_d;
	logic [SZW-1:0] req_q, size_q, size_d;
	logic [IW-1:0] id_q;
	logic [2:0] res_q, res_d;
	logic [MAX_IDS-1:0] used_q;
	node_t map_q [MAX_IDS];
	mreq_t mreq;
	nst_t rdata;
	logic clearing;
	logic have_id;
	logic [IW-1:0] low_id;
	logic set_id, clr_id;

	bta_node_mem u_mem (
		.clk(clk), .arst_n(arst_n), .req(mreq), .clearing(clearing), .rdata(rdata)
	);

	always_comb begin
		have_id = 1'b0;
		low_id = '0;
		for (int i = MAX_IDS - 1; i >= 0; i--)
			if (!used_q[i]) begin
				have_id = 1'b1;
				low_id = IW'(i);
			end
	end

	function automatic node_t parent(node_t n);
		node_t m;
		m = n - 1'b1;
		return {1'b0, m[NW-1:1]};
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			used_q <= '0;
		end else begin
			st_q <= st_d;
			if (set_id) used_q[id_q] <= 1'b1;
			if (clr_id) used_q[id_q] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && start && !clearing) begin
			req_q <= req_size;
			id_q <= func ? free_id : low_id;
		end
		if (set_id) map_q[id_q] <= node_q;
		cur_q <= cur_d;
		last_q <= last_d;
		anc_q <= anc_d;
		node_q <= node_d;
		size_q <= size_d;
		res_q <= res_d;
	end

	always_comb begin
		st_d = st_q;
		cur_d = cur_q;
		last_d = last_q;
		anc_d = anc_q;
		node_d = node_q;
		size_d = size_q;
		res_d = res_q;
		mreq = '0;
		set_id = 1'b0;
		clr_id = 1'b0;
		unique case (st_q)
			ST_IDLE: if (start && !clearing) begin
				size_d = SZW'(TOTAL_UNITS);
				cur_d = '0;
				last_d = '0;
				node_d = '0;
				if (func) begin
					if (!used_q[free_id]) begin
						res_d = S_UNUSED;
						st_d = ST_DONE;
					end else begin
						node_d = map_q[free_id];
						cur_d = map_q[free_id];
						st_d = ST_FREE_RD;
					end
				end else if (req_size == '0 || req_size > SZW'(TOTAL_UNITS)) begin
					res_d = S_BADSIZE;
					st_d = ST_DONE;
				end else if (!have_id) begin
					res_d = S_NOID;
					st_d = ST_DONE;
				end else
					st_d = ST_LEVEL;
			end
			// one halving per cycle; cur/last track the level's node range
			ST_LEVEL: begin
				if (req_q > {1'b0, size_q[SZW-1:1]} || size_q <= SZW'(1)) begin
					if (req_q > size_q) begin
						res_d = S_NOSPACE;
						st_d = ST_DONE;
					end else
						st_d = ST_SCAN;
				end else begin
					size_d = {1'b0, size_q[SZW-1:1]};
					cur_d = {cur_q[NW-2:0], 1'b1};
					last_d = {last_q[NW-2:0], 1'b0} + NW'(2);
				end
			end
			ST_SCAN: begin
				if (cur_q > last_q || cur_q >= NW'(NODE_SLOTS)) begin
					res_d = S_NOSPACE;
					st_d = ST_DONE;
				end else begin
					mreq.re = 1'b1;
					mreq.addr = cur_q;
					st_d = ST_SCAN_W;
				end
			end
			ST_SCAN_W: begin
				if (rdata != ST_FREE) begin
					cur_d = cur_q + 1'b1;
					st_d = ST_SCAN;
				end else begin
					anc_d = cur_q;
					st_d = ST_ANC;
				end
			end
			ST_ANC: begin
				if (anc_q == '0) begin
					node_d = cur_q;
					anc_d = cur_q;
					st_d = ST_MARK;
				end else begin
					mreq.re = 1'b1;
					mreq.addr = parent(anc_q);
					anc_d = parent(anc_q);
					st_d = ST_ANC_W;
				end
			end
			ST_ANC_W: begin
				if (rdata == ST_OCC) begin
					cur_d = cur_q + 1'b1;
					st_d = ST_SCAN;
				end else
					st_d = ST_ANC;
			end
			ST_MARK: begin
				mreq.we = 1'b1;
				mreq.addr = anc_q;
				mreq.wdata = (anc_q == node_q) ? ST_OCC : ST_SPLIT;
				if (anc_q == '0) begin
					set_id = 1'b1;
					res_d = S_ALLOC;
					st_d = ST_DONE;
				end else
					anc_d = parent(anc_q);
			end
			// free node at cur, then read sibling to decide merge
			ST_FREE_RD: begin
				mreq.we = 1'b1;
				mreq.addr = cur_q;
				mreq.wdata = ST_FREE;
				anc_d = '1;
				if (cur_q == '0) begin
					clr_id = 1'b1;
					res_d = S_FREED;
					st_d = ST_DONE;
				end else
					st_d = ST_FREE_W;
			end
			ST_FREE_W: begin
				if (anc_q == '1) begin
					mreq.re = 1'b1;
					mreq.addr = cur_q[0] ? cur_q + 1'b1 : cur_q - 1'b1;
					anc_d = '0;
				end else if (rdata == ST_FREE) begin
					cur_d = parent(cur_q);
					anc_d = '1;
					st_d = ST_FREE_RD;
				end else begin
					clr_id = 1'b1;
					res_d = S_FREED;
					st_d = ST_DONE;
				end
			end
			ST_DONE: st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	assign busy = (st_q != ST_IDLE) || clearing;
	assign done = (st_q == ST_DONE);
	assign status = res_q;
	assign alloc_id = (res_q == S_ALLOC || res_q == S_FREED) ? id_q : '0;
	assign tree_node = (res_q == S_ALLOC || res_q == S_FREED) ? node_q : '0;
endmodule

// File: rtl/bta_checker.sv
// Port checker for the buddy allocator, bound to the top level.
module bta_port_props (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic [2:0] status,
	input logic [10:0] tree_node
);
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("strobe while idle");
	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("strobe held");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> status <= 3'd5) else $error("bad status");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status >= 3'd2 |-> tree_node == '0) else $error("error with node");
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("start ignored");
endmodule

bind buddy_tree_allocator_top bta_port_props u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.status(status), .tree_node(tree_node)
);
